[sv/text_console_writer_assert.svh]
// ----------------------------------------------------------------------------
// text_console_writer_assert.svh
// Assertion macros for the text console writer checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared codes, command and status types for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_BLANK     = 8'h20;
	localparam logic [7:0] CH_ERR       = 8'h45;
	localparam logic [7:0] ATTR_ERR     = 8'hF4;

	typedef struct packed {
		logic is_put;
		logic is_clear;
		logic is_read;
		logic use_pos;
		logic in_range;
		logic is_newline;
		logic is_backspace;
		logic at_home;
		logic row_over;
		logic copy_more;
		logic cnt_last;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic load_req;
		logic set_work;
		logic mark_err;
		logic set_perr;
		logic cap_read;
		logic put_exec;
		logic scroll_begin;
		logic copy_rd;
		logic copy_wr;
		logic zero_wr;
		logic fill_wr;
		logic cnt_clear;
		logic home_work;
		logic emit;
	} cmd_t;

	function automatic int addr_bits(input int n);
		return (n < 2) ? 1 : $clog2(n);
	endfunction

endpackage

[sv/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram
	import tcw_pkg::*;
#(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [addr_bits(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]            wdata,
	input  logic [addr_bits(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the text console writer: decodes requests and steps
// the datapath through put, scroll, fill, read and reset clearing.
// ----------------------------------------------------------------------------
module tcw_ctrl
	import tcw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DECODE = 4'd2;
	localparam logic [3:0] S_PUT    = 4'd3;
	localparam logic [3:0] S_CHECK  = 4'd4;
	localparam logic [3:0] S_SCR_RD = 4'd5;
	localparam logic [3:0] S_SCR_WR = 4'd6;
	localparam logic [3:0] S_ZROW   = 4'd7;
	localparam logic [3:0] S_FILL   = 4'd8;
	localparam logic [3:0] S_RDWAIT = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				cmd.zero_wr = 1'b1;
				if (status.cnt_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.set_work = 1'b1;
				if (status.is_put) begin
					cmd.mark_err = status.use_pos && !status.in_range;
					state_d      = S_PUT;
				end else if (status.is_clear) begin
					cmd.cnt_clear = 1'b1;
					state_d       = S_FILL;
				end else if (status.is_read) begin
					if (status.in_range) begin
						state_d = S_RDWAIT;
					end else begin
						cmd.set_perr = 1'b1;
						state_d      = S_DONE;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_PUT: begin
				cmd.put_exec = 1'b1;
				state_d      = S_CHECK;
			end
			S_CHECK: begin
				if (status.row_over) begin
					cmd.scroll_begin = 1'b1;
					state_d          = S_SCR_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCR_RD: begin
				if (status.copy_more) begin
					cmd.copy_rd = 1'b1;
					state_d     = S_SCR_WR;
				end else begin
					state_d = S_ZROW;
				end
			end
			S_SCR_WR: begin
				cmd.copy_wr = 1'b1;
				state_d     = S_SCR_RD;
			end
			S_ZROW: begin
				cmd.zero_wr = 1'b1;
				if (status.cnt_last) begin
					state_d = S_DONE;
				end
			end
			S_FILL: begin
				cmd.fill_wr = 1'b1;
				if (status.cnt_last) begin
					cmd.home_work = 1'b1;
					state_d       = S_DONE;
				end
			end
			S_RDWAIT: begin
				cmd.cap_read = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/tcw_dp.sv]
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath for the text console writer: request registers, cursor and
// working position, sweep counter, screen store and result register.
// ----------------------------------------------------------------------------
module tcw_dp
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [1:0]                          req_type,
	input  logic [7:0]                          char_code,
	input  logic [7:0]                          attribute,
	input  logic                                use_position,
	input  logic [4:0]                          row,
	input  logic [6:0]                          col,
	input  cmd_t                                cmd,
	output status_t                             status,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [addr_bits(COLUMNS*ROWS)-1:0] cursor_cell,
	output logic [7:0]                          read_char,
	output logic [7:0]                          read_attr,
	output logic                                scrolled,
	output logic                                position_error
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = addr_bits(CELLS);
	localparam int RW    = addr_bits(ROWS + 1);
	localparam int CW    = addr_bits(COLUMNS);

	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
	localparam logic [RW-1:0] ROW_END   = RW'(ROWS);
	localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);

	logic [1:0]    req_type_q;
	logic [7:0]    char_q;
	logic [7:0]    attr_q;
	logic          use_pos_q;
	logic [4:0]    row_q;
	logic [6:0]    col_q;

	logic [RW-1:0] cur_row_q;
	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] wr_q;
	logic [CW-1:0] wc_q;
	logic [AW-1:0] cnt_q;

	logic          perr_q;
	logic          scr_q;
	logic [7:0]    rch_q;
	logic [7:0]    rat_q;

	logic [AW-1:0] work_addr;
	logic [AW-1:0] req_addr;
	logic [AW-1:0] copy_addr;
	logic          in_range;
	logic          is_put;
	logic          at_home;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	assign work_addr = AW'(32'(wr_q) * COLUMNS + 32'(wc_q));
	assign req_addr  = AW'(32'(row_q) * COLUMNS + 32'(col_q));
	assign copy_addr = AW'(32'(cnt_q) + COLUMNS);
	assign in_range  = (32'(row_q) < ROWS) && (32'(col_q) < COLUMNS);
	assign is_put    = (req_type_q == REQ_PUT);
	assign at_home   = (wr_q == '0) && (wc_q == '0);

	always_comb begin
		status              = '0;
		status.is_put       = is_put;
		status.is_clear     = (req_type_q == REQ_CLEAR);
		status.is_read      = (req_type_q == REQ_READ);
		status.use_pos      = use_pos_q;
		status.in_range     = in_range;
		status.is_newline   = (char_q == CH_NEWLINE);
		status.is_backspace = (char_q == CH_BACKSPACE);
		status.at_home      = at_home;
		status.row_over     = (wr_q == ROW_END);
		status.copy_more    = (cnt_q < COPY_END);
		status.cnt_last     = (cnt_q == LAST_CELL);
		status.out_free     = !out_valid || out_ready;
	end

	// store write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		if (cmd.mark_err) begin
			ram_we    = 1'b1;
			ram_waddr = LAST_CELL;
			ram_wdata = {ATTR_ERR, CH_ERR};
		end else if (cmd.put_exec) begin
			if (status.is_backspace) begin
				ram_we    = !at_home;
				ram_waddr = work_addr - AW'(1);
				ram_wdata = {attr_q, CH_BLANK};
			end else if (!status.is_newline) begin
				ram_we    = 1'b1;
				ram_waddr = work_addr;
				ram_wdata = {attr_q, char_q};
			end
		end else if (cmd.copy_wr) begin
			ram_we    = 1'b1;
			ram_wdata = ram_rdata;
		end else if (cmd.zero_wr) begin
			ram_we = 1'b1;
		end else if (cmd.fill_wr) begin
			ram_we    = 1'b1;
			ram_wdata = {attr_q, char_q};
		end
	end

	assign ram_raddr = cmd.copy_rd ? copy_addr : req_addr;

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_type_q <= req_type;
			char_q     <= char_code;
			attr_q     <= attribute;
			use_pos_q  <= use_position;
			row_q      <= row;
			col_q      <= col;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			perr_q <= 1'b0;
			scr_q  <= 1'b0;
			rch_q  <= '0;
			rat_q  <= '0;
		end else begin
			if (cmd.mark_err || cmd.set_perr) begin
				perr_q <= 1'b1;
			end
			if (cmd.scroll_begin) begin
				scr_q <= 1'b1;
			end
			if (cmd.cap_read) begin
				rch_q <= ram_rdata[7:0];
				rat_q <= ram_rdata[15:8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q      <= '0;
			wc_q      <= '0;
			cur_row_q <= '0;
			cur_col_q <= '0;
		end else begin
			if (cmd.set_work) begin
				if (is_put && use_pos_q && in_range) begin
					wr_q <= RW'(row_q);
					wc_q <= CW'(col_q);
				end else begin
					wr_q <= cur_row_q;
					wc_q <= cur_col_q;
				end
			end else if (cmd.put_exec) begin
				if (status.is_newline) begin
					wr_q <= wr_q + RW'(1);
					wc_q <= '0;
				end else if (status.is_backspace) begin
					if (!at_home) begin
						if (wc_q == '0) begin
							wr_q <= wr_q - RW'(1);
							wc_q <= COL_LAST;
						end else begin
							wc_q <= wc_q - CW'(1);
						end
					end
				end else if (wc_q == COL_LAST) begin
					wr_q <= wr_q + RW'(1);
					wc_q <= '0;
				end else begin
					wc_q <= wc_q + CW'(1);
				end
			end else if (cmd.scroll_begin) begin
				wr_q <= ROW_LAST;
			end else if (cmd.home_work) begin
				wr_q <= '0;
				wc_q <= '0;
			end
			if (cmd.emit) begin
				cur_row_q <= wr_q;
				cur_col_q <= wc_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clear || cmd.scroll_begin) begin
			cnt_q <= '0;
		end else if (cmd.copy_wr || cmd.zero_wr || cmd.fill_wr) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cursor_cell    <= work_addr;
			read_char      <= rch_q;
			read_attr      <= rat_q;
			scrolled       <= scr_q;
			position_error <= perr_q;
		end
	end

endmodule

[sv/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell console: screen store with cursor, put, clear and read.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | req_type char_code attribute use_position row col
//  out     | out_valid / out_ready| cursor_cell read_char read_attr scrolled position_error
//
// One item at a time. A put may scroll the screen; a clear fills every
// cell, one store write a cycle through the single write port.
// After reset a clearing pass zeroes all CELLS cells (2000 at the default
// size) with in_ready low.
// A stalled result holds in the output register while the next item is
// taken; that item waits at its end until the register frees.
// ----------------------------------------------------------------------------
module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          req_type,
	input  logic [7:0]                          char_code,
	input  logic [7:0]                          attribute,
	input  logic                                use_position,
	input  logic [4:0]                          row,
	input  logic [6:0]                          col,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [addr_bits(COLUMNS*ROWS)-1:0] cursor_cell,
	output logic [7:0]                          read_char,
	output logic [7:0]                          read_attr,
	output logic                                scrolled,
	output logic                                position_error
);

	cmd_t    cmd;
	status_t status;

	tcw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	tcw_dp #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_type      (req_type),
		.char_code     (char_code),
		.attribute     (attribute),
		.use_position  (use_position),
		.row           (row),
		.col           (col),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.cursor_cell   (cursor_cell),
		.read_char     (read_char),
		.read_attr     (read_attr),
		.scrolled      (scrolled),
		.position_error(position_error)
	);

endmodule

[sv/tcw_checker.sv]
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module tcw_checker
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic [1:0]                          req_type,
	input logic [7:0]                          char_code,
	input logic [7:0]                          attribute,
	input logic                                use_position,
	input logic [4:0]                          row,
	input logic [6:0]                          col,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [addr_bits(COLUMNS*ROWS)-1:0] cursor_cell,
	input logic [7:0]                          read_char,
	input logic [7:0]                          read_attr,
	input logic                                scrolled,
	input logic                                position_error
);

	localparam int AW = addr_bits(COLUMNS * ROWS);
	localparam logic [AW:0] CELL_COUNT = (AW+1)'(COLUMNS * ROWS);
	localparam logic [AW-1:0] LAST_ROW_START = AW'((ROWS - 1) * COLUMNS);

	`TCW_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
		in_valid && $stable(req_type) && $stable(char_code) && $stable(attribute) &&
		$stable(use_position) && $stable(row) && $stable(col), "item changed while waiting")
	`TCW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(cursor_cell) && $stable(scrolled), "result changed while stalled")
	`TCW_ASSERT_NOW(a_cursor_range, out_valid, {1'b0, cursor_cell} < CELL_COUNT,
		"cursor beyond screen")
	`TCW_ASSERT_NOW(a_read_only, out_valid && ((read_char != 8'd0) || (read_attr != 8'd0)),
		!scrolled && !position_error, "read data on a non-read result")
	`TCW_ASSERT_NOW(a_scroll_cursor, out_valid && scrolled, cursor_cell == LAST_ROW_START,
		"cursor not at last row start after scroll")

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcw_checker (.*);
